### rtl/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg : shared types and constants for the differential drive odometry
// Item structs, sequencer state codes, register indexes, angle constants,
// the arctangent table and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package odo_pkg;

  // Configuration register indexes
  localparam logic REG_DIST_PER_REV  = 1'b0;
  localparam logic REG_INV_TWO_TREAD = 1'b1;

  localparam logic [31:0] DIST_PER_REV_RST  = 32'd8968;
  localparam logic [31:0] INV_TWO_TREAD_RST = 32'd819200;

  // Angle constants in Q30 radians
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
  localparam logic signed [34:0] ONE_Q30     = 35'sd1073741824;
  localparam int unsigned        CORDIC_STEPS = 30;

  // Microseconds per second
  localparam logic signed [33:0] US_PER_S = 34'sd1000000;

  typedef struct packed {
    logic signed [31:0] left_position;
    logic signed [31:0] right_position;
    logic [19:0]        elapsed_us;
  } odo_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_turn;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
  } odo_out_t;

  // Wheel deltas as handed from the front to the back
  typedef struct packed {
    logic signed [31:0] delta_left;
    logic signed [31:0] delta_right;
    logic [19:0]        elapsed_us;
  } odo_step_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TL,
    ST_TR,
    ST_TRAVEL,
    ST_TURN,
    ST_ANGLE,
    ST_MOD,
    ST_FOLD,
    ST_ROT,
    ST_CLAMP,
    ST_STEP_X,
    ST_STEP_Y,
    ST_POSE,
    ST_SCALE_X,
    ST_SCALE_Y,
    ST_SCALE_T,
    ST_DIV_INIT,
    ST_DIV,
    ST_PUT
  } odo_state_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      5'd24: r = 32'h0000003F;
      5'd25: r = 32'h0000001F;
      5'd26: r = 32'h0000000F;
      5'd27: r = 32'h00000008;
      5'd28: r = 32'h00000004;
      5'd29: r = 32'h00000002;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

### rtl/differential_drive_odometry.sv
// Sequence: two angle passes of a FRAC_BITS-dependent reduction plus a
//   30-step CORDIC each, and a bit-serial division for velocities.
// One item at a time in the back; the input queue holds two more items.
// Reset: rst_n synchronous, active low; clears pose, last positions, queues,
//   and loads the register defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry : dead-reckoning pose from wheel positions
// Front forms wheel deltas, a short queue decouples it from the back, which
// updates the pose and returns pose, velocities and yaw quaternion.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  odo_pkg::odo_in_t  in_data,
  output logic              out_empty,
  input  logic              out_pop,
  output odo_pkg::odo_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_idx,
  input  logic [31:0]       cfg_data
);

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  odo_pkg::odo_step_t q_wdata;
  odo_pkg::odo_step_t q_rdata;

  assign in_full = q_full;

  odo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  odo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  odo_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res_data  (out_data)
  );

endmodule

### rtl/odo_queue.sv
// ----------------------------------------------------------------------------
// odo_queue : two-entry queue of wheel-delta items
// Decouples the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module odo_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  odo_pkg::odo_step_t push_data,
  output logic              full,
  input  logic              pop,
  output odo_pkg::odo_step_t pop_data,
  output logic              empty
);

  odo_pkg::odo_step_t mem_r [2];
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               do_push;
  logic               do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Store an item
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/odo_front.sv
// ----------------------------------------------------------------------------
// odo_front : input side of the odometry block
// Accepts position items, forms wheel deltas against the last positions and
// hands them to the queue.
// ----------------------------------------------------------------------------
module odo_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  odo_pkg::odo_in_t   in_data,
  input  logic               q_full,
  output logic               q_push,
  output odo_pkg::odo_step_t q_data
);

  logic signed [31:0] last_left_r;
  logic signed [31:0] last_right_r;

  assign q_push = in_push && !q_full;

  // Wrapping difference against the stored positions
  always_comb begin
    q_data.delta_left  = in_data.left_position - last_left_r;
    q_data.delta_right = in_data.right_position - last_right_r;
    q_data.elapsed_us  = in_data.elapsed_us;
  end

  // Remember the positions of each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r  <= '0;
      last_right_r <= '0;
    end else if (q_push) begin
      last_left_r  <= in_data.left_position;
      last_right_r <= in_data.right_position;
    end
  end

endmodule

### rtl/odo_back.sv
// ----------------------------------------------------------------------------
// odo_back : pose sequencer of the odometry block
// Runs one shared multiplier, an angle reduction unit, a CORDIC rotator and
// three bit-serial dividers in sequence, and keeps the pose and registers.
// ----------------------------------------------------------------------------
module odo_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               q_empty,
  input  odo_pkg::odo_step_t q_data,
  output logic               q_pop,
  output logic               res_empty,
  input  logic               res_pop,
  output odo_pkg::odo_out_t  res_data
);

  localparam int MW       = 63 - FRAC_BITS;
  localparam int KMAX     = MW - 33;
  localparam int KW       = $clog2(KMAX + 1);
  localparam int SH_HEAD  = 30 - FRAC_BITS;
  localparam int SH_HALF  = 29 - FRAC_BITS;
  localparam int NB       = 51;
  localparam int CW       = $clog2(NB + 1);

  odo_pkg::odo_state_t state_r, state_nxt;

  logic [31:0]        dpr_r;
  logic [31:0]        itt_r;
  logic signed [31:0] acc_x_r, acc_y_r, acc_h_r;
  logic signed [31:0] dl_r, dr_r;
  logic [19:0]        us_r;
  logic signed [31:0] tl_r, tr_r, mean_r, dth_r;
  logic signed [33:0] dx_r, dy_r;
  logic signed [67:0] prod_r;
  logic signed [33:0] op_a, op_b;
  logic               phase_r;
  logic [63:0]        mag_r;
  logic               neg_r;
  logic [KW-1:0]      k_r;
  logic signed [35:0] r_r;
  logic signed [34:0] x_r, y_r;
  logic [4:0]         i_r;
  logic               flip_r;
  logic signed [31:0] cos_r, sin_r;
  logic [NB-1:0]      num_r [3];
  logic [19:0]        rem_r [3];
  logic               vneg_r [3];
  logic [CW-1:0]      cnt_r;
  odo_pkg::odo_out_t  res_r;
  logic               res_valid_r;

  logic signed [31:0] dth_c;
  logic signed [63:0] ang_c;
  logic [63:0]        cand_c;
  logic signed [35:0] r0_c, r1_c;
  logic signed [34:0] xs_c, ys_c;
  logic signed [35:0] at_c;
  logic signed [31:0] cc_c, sc_c;
  logic [NB-1:0]      pmag_c;
  logic signed [31:0] vel_c [3];
  logic               put_c;

  assign q_pop     = (state_r == odo_pkg::ST_IDLE) && !q_empty;
  assign put_c     = (state_r == odo_pkg::ST_PUT) && (!res_valid_r || res_pop);
  assign res_empty = !res_valid_r;
  assign res_data  = res_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      odo_pkg::ST_IDLE:     if (!q_empty) state_nxt = odo_pkg::ST_TL;
      odo_pkg::ST_TL:       state_nxt = odo_pkg::ST_TR;
      odo_pkg::ST_TR:       state_nxt = odo_pkg::ST_TRAVEL;
      odo_pkg::ST_TRAVEL:   state_nxt = odo_pkg::ST_TURN;
      odo_pkg::ST_TURN:     state_nxt = odo_pkg::ST_ANGLE;
      odo_pkg::ST_ANGLE:    state_nxt = odo_pkg::ST_MOD;
      odo_pkg::ST_MOD:      if (k_r == '0) state_nxt = odo_pkg::ST_FOLD;
      odo_pkg::ST_FOLD:     state_nxt = odo_pkg::ST_ROT;
      odo_pkg::ST_ROT:
        if (i_r == 5'(odo_pkg::CORDIC_STEPS - 1)) state_nxt = odo_pkg::ST_CLAMP;
      odo_pkg::ST_CLAMP:
        state_nxt = phase_r ? odo_pkg::ST_SCALE_X : odo_pkg::ST_STEP_X;
      odo_pkg::ST_STEP_X:   state_nxt = odo_pkg::ST_STEP_Y;
      odo_pkg::ST_STEP_Y:   state_nxt = odo_pkg::ST_POSE;
      odo_pkg::ST_POSE:     state_nxt = odo_pkg::ST_ANGLE;
      odo_pkg::ST_SCALE_X:  state_nxt = odo_pkg::ST_SCALE_Y;
      odo_pkg::ST_SCALE_Y:  state_nxt = odo_pkg::ST_SCALE_T;
      odo_pkg::ST_SCALE_T:  state_nxt = odo_pkg::ST_DIV_INIT;
      odo_pkg::ST_DIV_INIT: state_nxt = odo_pkg::ST_DIV;
      odo_pkg::ST_DIV:      if (cnt_r == CW'(NB - 1)) state_nxt = odo_pkg::ST_PUT;
      odo_pkg::ST_PUT:      if (put_c) state_nxt = odo_pkg::ST_IDLE;
      default:              state_nxt = odo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= odo_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      odo_pkg::ST_TL: begin
        op_a = 34'(dl_r);
        op_b = $signed({2'b00, dpr_r});
      end
      odo_pkg::ST_TR: begin
        op_a = 34'(dr_r);
        op_b = $signed({2'b00, dpr_r});
      end
      odo_pkg::ST_TURN: begin
        op_a = 34'(odo_pkg::sat32(68'(tr_r) - 68'(tl_r)));
        op_b = $signed({2'b00, itt_r});
      end
      odo_pkg::ST_STEP_X: begin
        op_a = 34'(mean_r);
        op_b = 34'(cos_r);
      end
      odo_pkg::ST_STEP_Y: begin
        op_a = 34'(mean_r);
        op_b = 34'(sin_r);
      end
      odo_pkg::ST_SCALE_X: begin
        op_a = dx_r;
        op_b = odo_pkg::US_PER_S;
      end
      odo_pkg::ST_SCALE_Y: begin
        op_a = dy_r;
        op_b = odo_pkg::US_PER_S;
      end
      odo_pkg::ST_SCALE_T: begin
        op_a = 34'(dth_r);
        op_b = odo_pkg::US_PER_S;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Angle reduction, CORDIC step and clamp logic
  always_comb begin
    dth_c = odo_pkg::sat32(prod_r >>> FRAC_BITS);
    if (phase_r) begin
      ang_c = 64'(acc_h_r) <<< SH_HALF;
    end else begin
      ang_c = (64'(acc_h_r) <<< SH_HEAD) + (64'(dth_c) <<< SH_HALF);
    end
    cand_c = {28'd0, odo_pkg::TWO_PI_Q30} << k_r;

    if (neg_r && (mag_r[33:0] != 34'd0)) begin
      r0_c = odo_pkg::TWO_PI_Q30 - $signed({2'b00, mag_r[33:0]});
    end else begin
      r0_c = $signed({2'b00, mag_r[33:0]});
    end
    r1_c = (r0_c >= odo_pkg::PI_Q30) ? r0_c - odo_pkg::TWO_PI_Q30 : r0_c;

    xs_c = x_r >>> i_r;
    ys_c = y_r >>> i_r;
    at_c = $signed({4'b0000, odo_pkg::atan_q30(i_r)});

    if (x_r > odo_pkg::ONE_Q30) begin
      cc_c = 32'(odo_pkg::ONE_Q30);
    end else if (x_r < -odo_pkg::ONE_Q30) begin
      cc_c = 32'(-odo_pkg::ONE_Q30);
    end else begin
      cc_c = x_r[31:0];
    end
    if (y_r > odo_pkg::ONE_Q30) begin
      sc_c = 32'(odo_pkg::ONE_Q30);
    end else if (y_r < -odo_pkg::ONE_Q30) begin
      sc_c = 32'(-odo_pkg::ONE_Q30);
    end else begin
      sc_c = y_r[31:0];
    end

    pmag_c = prod_r[67] ? NB'(-prod_r) : NB'(prod_r);
  end

  // Saturate the quotients with their signs; zero when no time elapsed
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (us_r == 20'd0) begin
        vel_c[l] = '0;
      end else if (vneg_r[l]) begin
        vel_c[l] = (num_r[l] > NB'(64'd2147483648)) ? 32'sh8000_0000
                                                    : -$signed(num_r[l][31:0]);
      end else begin
        vel_c[l] = (num_r[l] > NB'(64'd2147483647)) ? 32'sh7FFF_FFFF
                                                    : $signed(num_r[l][31:0]);
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpr_r <= odo_pkg::DIST_PER_REV_RST;
      itt_r <= odo_pkg::INV_TWO_TREAD_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        odo_pkg::REG_DIST_PER_REV:  dpr_r <= cfg_data;
        odo_pkg::REG_INV_TWO_TREAD: itt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pose and result holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      acc_h_r     <= '0;
      phase_r     <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (state_r == odo_pkg::ST_IDLE) begin
        phase_r <= 1'b0;
      end
      if (state_r == odo_pkg::ST_POSE) begin
        acc_x_r <= odo_pkg::sat32(68'(acc_x_r) + 68'(dx_r));
        acc_y_r <= odo_pkg::sat32(68'(acc_y_r) + (prod_r >>> 30));
        acc_h_r <= odo_pkg::sat32(68'(acc_h_r) + 68'(dth_r));
        phase_r <= 1'b1;
      end
      if (put_c) begin
        res_valid_r <= 1'b1;
      end else if (res_pop) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    case (state_r)
      odo_pkg::ST_IDLE: begin
        dl_r <= q_data.delta_left;
        dr_r <= q_data.delta_right;
        us_r <= q_data.elapsed_us;
      end
      odo_pkg::ST_TR:     tl_r <= odo_pkg::sat32(prod_r >>> FRAC_BITS);
      odo_pkg::ST_TRAVEL: tr_r <= odo_pkg::sat32(prod_r >>> FRAC_BITS);
      odo_pkg::ST_TURN: begin
        mean_r <= 32'((33'(tl_r) + 33'(tr_r)) >>> 1);
      end
      odo_pkg::ST_ANGLE: begin
        if (!phase_r) begin
          dth_r <= dth_c;
        end
        neg_r <= ang_c[63];
        mag_r <= ang_c[63] ? 64'(-ang_c) : 64'(ang_c);
        k_r   <= KW'(KMAX);
      end
      odo_pkg::ST_MOD: begin
        if (mag_r >= cand_c) begin
          mag_r <= mag_r - cand_c;
        end
        k_r <= k_r - KW'(1);
      end
      odo_pkg::ST_FOLD: begin
        if (r1_c > odo_pkg::HALF_PI_Q30) begin
          r_r    <= r1_c - odo_pkg::PI_Q30;
          flip_r <= 1'b1;
        end else if (r1_c < -odo_pkg::HALF_PI_Q30) begin
          r_r    <= r1_c + odo_pkg::PI_Q30;
          flip_r <= 1'b1;
        end else begin
          r_r    <= r1_c;
          flip_r <= 1'b0;
        end
        x_r <= odo_pkg::CORDIC_GAIN;
        y_r <= '0;
        i_r <= '0;
      end
      odo_pkg::ST_ROT: begin
        if (!r_r[35]) begin
          x_r <= x_r - ys_c;
          y_r <= y_r + xs_c;
          r_r <= r_r - at_c;
        end else begin
          x_r <= x_r + ys_c;
          y_r <= y_r - xs_c;
          r_r <= r_r + at_c;
        end
        i_r <= i_r + 5'd1;
      end
      odo_pkg::ST_CLAMP: begin
        cos_r <= flip_r ? -cc_c : cc_c;
        sin_r <= flip_r ? -sc_c : sc_c;
      end
      odo_pkg::ST_STEP_Y: dx_r <= 34'(prod_r >>> 30);
      odo_pkg::ST_POSE:   dy_r <= 34'(prod_r >>> 30);
      odo_pkg::ST_SCALE_Y: begin
        num_r[0]  <= pmag_c;
        vneg_r[0] <= prod_r[67];
      end
      odo_pkg::ST_SCALE_T: begin
        num_r[1]  <= pmag_c;
        vneg_r[1] <= prod_r[67];
      end
      odo_pkg::ST_DIV_INIT: begin
        num_r[2]  <= pmag_c;
        vneg_r[2] <= prod_r[67];
        for (int l = 0; l < 3; l++) begin
          rem_r[l] <= '0;
        end
        cnt_r <= '0;
      end
      odo_pkg::ST_DIV: begin
        // One quotient bit per lane per cycle
        for (int l = 0; l < 3; l++) begin
          if ({rem_r[l], num_r[l][NB-1]} >= {1'b0, us_r}) begin
            rem_r[l] <= 20'({rem_r[l], num_r[l][NB-1]} - {1'b0, us_r});
            num_r[l] <= {num_r[l][NB-2:0], 1'b1};
          end else begin
            rem_r[l] <= {rem_r[l][18:0], num_r[l][NB-1]};
            num_r[l] <= {num_r[l][NB-2:0], 1'b0};
          end
        end
        cnt_r <= cnt_r + CW'(1);
      end
      odo_pkg::ST_PUT: begin
        if (put_c) begin
          res_r.pos_x    <= acc_x_r;
          res_r.pos_y    <= acc_y_r;
          res_r.heading  <= acc_h_r;
          res_r.vel_x    <= vel_c[0];
          res_r.vel_y    <= vel_c[1];
          res_r.vel_turn <= vel_c[2];
          res_r.quat_z   <= sin_r;
          res_r.quat_w   <= cos_r;
        end
      end
      default: ;
    endcase
  end

endmodule

### tb/sv/tb_differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry : self-checking bench for the odometry block
// Drives wheel position items through the push/full queue, predicts the pose,
// velocities and yaw quaternion of each item in the bench, and compares every
// popped result field by field. Runs directed corners, register sweeps,
// random motion under several idling mixes, a long output stall and a drain.
// ----------------------------------------------------------------------------
module tb_differential_drive_odometry;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FRAC        = 16;
  localparam int          CYCLE_LIMIT = 4000000;
  localparam int          SETTLE      = 300;
  localparam longint      PI_RAD      = 64'sd3373259426;
  localparam longint      HALF_PI_RAD = 64'sd1686629713;
  localparam longint      TWO_PI_RAD  = 64'sd6746518852;
  localparam longint      GAIN_RAD    = 64'sd652032874;
  localparam longint      UNIT_Q30    = 64'sd1073741824;
  localparam longint      I32_HI      = 64'sd2147483647;
  localparam longint      I32_LO      = -64'sd2147483648;
  localparam longint      ARCTAN_TBL [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  odo_pkg::odo_in_t  in_data = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  odo_pkg::odo_out_t out_data;
  logic              cfg_we = 1'b0;
  logic              cfg_idx = odo_pkg::REG_DIST_PER_REV;
  logic [31:0]       cfg_data = '0;

  // bench copy of the registers and the pose
  logic [31:0]        dist_per_rev_q;
  logic [31:0]        inv_two_tread_q;
  logic signed [31:0] prev_left;
  logic signed [31:0] prev_right;
  longint             pose_x;
  longint             pose_y;
  longint             pose_heading;

  odo_pkg::odo_out_t expected_poses[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;
  int       hold_cycles = 0;
  logic signed [31:0] drive_left = '0;
  logic signed [31:0] drive_right = '0;

  differential_drive_odometry dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint clip32(longint v);
    return (v > I32_HI) ? I32_HI : ((v < I32_LO) ? I32_LO : v);
  endfunction

  function automatic longint scale_q(longint a, logic [31:0] b);
    return clip32((a * longint'({32'h0, b})) >>> FRAC);
  endfunction

  function automatic longint rate_of(longint step, logic [19:0] us);
    if (us == 0) return 0;
    return clip32((step * 64'sd1000000) / longint'({44'h0, us}));
  endfunction

  // CORDIC rotation of a Q30 angle; sine and cosine in Q1.30
  function automatic void rotate_angle(longint ang, output longint s, output longint c);
    longint r, x, y, nx;
    logic   flip;
    r = ang % TWO_PI_RAD;
    x = GAIN_RAD;
    y = 0;
    flip = 1'b0;
    if (r < 0) r += TWO_PI_RAD;
    if (r >= PI_RAD) r -= TWO_PI_RAD;
    if (r > HALF_PI_RAD) begin
      r -= PI_RAD;
      flip = 1'b1;
    end else if (r < -HALF_PI_RAD) begin
      r += PI_RAD;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (r >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        r -= ARCTAN_TBL[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        r += ARCTAN_TBL[i];
      end
      x = nx;
    end
    if (x > UNIT_Q30) x = UNIT_Q30;
    if (x < -UNIT_Q30) x = -UNIT_Q30;
    if (y > UNIT_Q30) y = UNIT_Q30;
    if (y < -UNIT_Q30) y = -UNIT_Q30;
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the bench pose by one item and return the expected result
  function automatic odo_pkg::odo_out_t advance_pose(odo_pkg::odo_in_t it);
    logic signed [31:0] dl32, dr32;
    longint tl, tr, mean, dth, s, c, dx, dy, qz, qw;
    odo_pkg::odo_out_t res;
    dl32 = it.left_position - prev_left;
    dr32 = it.right_position - prev_right;
    prev_left = it.left_position;
    prev_right = it.right_position;
    tl = scale_q(longint'(dl32), dist_per_rev_q);
    tr = scale_q(longint'(dr32), dist_per_rev_q);
    mean = (tl + tr) >>> 1;
    dth = scale_q(clip32(tr - tl), inv_two_tread_q);
    rotate_angle((pose_heading <<< (30 - FRAC)) + (dth <<< (29 - FRAC)), s, c);
    dx = (mean * c) >>> 30;
    dy = (mean * s) >>> 30;
    pose_x = clip32(pose_x + dx);
    pose_y = clip32(pose_y + dy);
    pose_heading = clip32(pose_heading + dth);
    rotate_angle(pose_heading <<< (29 - FRAC), qz, qw);
    res.pos_x    = pose_x[31:0];
    res.pos_y    = pose_y[31:0];
    res.heading  = pose_heading[31:0];
    res.vel_x    = 32'(rate_of(dx, it.elapsed_us));
    res.vel_y    = 32'(rate_of(dy, it.elapsed_us));
    res.vel_turn = 32'(rate_of(dth, it.elapsed_us));
    res.quat_z   = qz[31:0];
    res.quat_w   = qw[31:0];
    return res;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
      mismatches++;
    end
  endfunction

  // Check each popped result against the oldest expectation
  always @(posedge clk) begin
    odo_pkg::odo_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_poses.size() == 0) begin
        $error("result with no item outstanding");
        mismatches++;
      end else begin
        want = expected_poses.pop_front();
        compare_field("pos_x", want.pos_x, out_data.pos_x);
        compare_field("pos_y", want.pos_y, out_data.pos_y);
        compare_field("heading", want.heading, out_data.heading);
        compare_field("vel_x", want.vel_x, out_data.vel_x);
        compare_field("vel_y", want.vel_y, out_data.vel_y);
        compare_field("vel_turn", want.vel_turn, out_data.vel_turn);
        compare_field("quat_z", want.quat_z, out_data.quat_z);
        compare_field("quat_w", want.quat_w, out_data.quat_w);
      end
    end
  end

  // Drive pop: hold off while a stall is counting down, else stall at random
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_pop = 1'b0;
      hold_cycles--;
    end else begin
      out_pop = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  task automatic send_item(logic signed [31:0] lp, logic signed [31:0] rp, logic [19:0] us);
    @(negedge clk);
    in_push = 1'b1;
    in_data.left_position = lp;
    in_data.right_position = rp;
    in_data.elapsed_us = us;
    do @(posedge clk); while (in_full);
    expected_poses.push_back(advance_pose(in_data));
    drive_left = lp;
    drive_right = rp;
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_push = 1'b0;
    end
  endtask

  // Drop push and wait until every expected result has arrived
  task automatic drain();
    @(negedge clk);
    in_push = 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    if (idx == odo_pkg::REG_DIST_PER_REV) dist_per_rev_q = val;
    else inv_two_tread_q = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Mostly smooth motion from the last positions, some arbitrary jumps
  task automatic send_random_item();
    logic signed [31:0] lp, rp;
    logic [19:0] us;
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      lp = drive_left + $signed($urandom_range(4000)) - 2000;
      rp = drive_right + $signed($urandom_range(4000)) - 2000;
    end else if (sel < 90) begin
      lp = drive_left + $signed($urandom_range(2000000)) - 1000000;
      rp = drive_right + $signed($urandom_range(2000000)) - 1000000;
    end else begin
      lp = $urandom;
      rp = $urandom;
    end
    case ($urandom_range(9))
      0: us = 20'd0;
      1: us = 20'd1;
      2: us = 20'($urandom_range(64, 1));
      default: us = 20'($urandom_range(1000000, 1));
    endcase
    send_item(lp, rp, us);
  endtask

  task automatic apply_reset();
    dist_per_rev_q = odo_pkg::DIST_PER_REV_RST;
    inv_two_tread_q = odo_pkg::INV_TWO_TREAD_RST;
    prev_left = '0;
    prev_right = '0;
    pose_x = 0;
    pose_y = 0;
    pose_heading = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  endtask

  // Corners of the fields, reset register values, saturation of the pose
  task automatic test_directed();
    send_item(32'sd0, 32'sd0, 20'd0);
    send_item(32'sd65536, 32'sd65536, 20'd16667);
    send_item(32'sd65536, 32'sd131072, 20'd1);
    send_item(32'sd131072, 32'sd65536, 20'd1000000);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 20'd1);
    send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 20'd0);
    send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 20'd524288);
    send_item(32'sh8000_0000, 32'sh7FFF_FFFF, 20'd999999);
    send_item(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 20'd1);
    send_item(32'sh8000_0000, 32'sh8000_0000, 20'd1);
    send_item(32'sh0000_0000, 32'sh7FFF_FFFF, 20'd1000000);
    send_item(32'sh7FFF_FFFF, 32'sh0000_0000, 20'd1);
    send_item(32'shFFFF_FFFF, 32'sh0000_0001, 20'd3);
    send_item(32'sh0000_0001, 32'shFFFF_FFFF, 20'd0);
    drain();
  endtask

  // Register extremes, each followed by a burst of items
  task automatic test_register_sweep();
    logic [31:0] dist_set [5] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd65536, $urandom};
    logic [31:0] tread_set [5] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd65536, $urandom};
    for (int p = 0; p < 5; p++) begin
      write_reg(odo_pkg::REG_DIST_PER_REV, dist_set[p]);
      write_reg(odo_pkg::REG_INV_TWO_TREAD, tread_set[p]);
      send_item(32'sh7FFF_FFFF, 32'sh8000_0000, 20'd1);
      repeat (20) send_random_item();
      drain();
    end
    write_reg(odo_pkg::REG_DIST_PER_REV, odo_pkg::DIST_PER_REV_RST);
    write_reg(odo_pkg::REG_INV_TWO_TREAD, odo_pkg::INV_TWO_TREAD_RST);
  endtask

  task automatic test_random_phase(int idle_pct, int stall_pct, int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_item();
    drain();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  // Hold the output off long enough for the block to fill and push back
  task automatic test_output_stall();
    hold_cycles = 2000;
    repeat (12) send_random_item();
    drain();
  endtask

  // Pause the sender until everything is out, then carry on
  task automatic test_sender_pause();
    repeat (5) send_random_item();
    drain();
    repeat (5) send_random_item();
    drain();
  endtask

  initial begin
    apply_reset();
    test_directed();
    test_register_sweep();
    test_random_phase(0, 0, 300);
    test_random_phase(53, 0, 300);
    test_random_phase(0, 53, 300);
    test_random_phase(26, 26, 300);
    test_output_stall();
    test_sender_pause();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
